### hdl/sgr_pkg.sv
// shared constants and types for the stream group reverser
`timescale 1ns / 1ps
package sgr_pkg;

    localparam int MAX_GROUP_DEF    = 16;
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int CFG_WIDTH        = 5;
    localparam logic [CFG_WIDTH-1:0] GROUP_SIZE_RST = CFG_WIDTH'(2);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

### hdl/sgr_if.sv
// stream channel interfaces for input and result words
`timescale 1ns / 1ps
interface sgr_in_if #(
    parameter int VALUE_WIDTH = sgr_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] item_value;
    logic                          list_end;

    modport source (output valid, output item_value, output list_end, input ready);
    modport sink   (input valid, input item_value, input list_end, output ready);
endinterface

interface sgr_out_if #(
    parameter int VALUE_WIDTH = sgr_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] out_value;
    logic                          run_last;
    logic                          out_list_end;

    modport source (output valid, output out_value, output run_last, output out_list_end,
                    input ready);
    modport sink   (input valid, input out_value, input run_last, input out_list_end,
                    output ready);
endinterface

### hdl/stream_group_reverser.sv
// top level: reverses a word stream in groups of the configured size; a short group closed by list_end passes in order
//
//   channel   dir   protocol      payload
//   i_in      in    valid/ready   item_value, list_end
//   o_out     out   valid/ready   out_value, run_last, out_list_end
//   i_cfg_*   in    write enable  group_size
//
// an input word that completes no group is only stored, and input stays ready
// a word that releases n buffered words holds off input while the n words drain:
// the group buffer has one read port, drained one entry per cycle while the output queue has room
// a read passes through the read data register, then the output register; a stalled sink stops the drain
// reset clears the fill count, the drain state and sets group size to 2
`timescale 1ns / 1ps
module stream_group_reverser #(
    parameter int MAX_GROUP   = sgr_pkg::MAX_GROUP_DEF,
    parameter int VALUE_WIDTH = sgr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sgr_pkg::CFG_WIDTH-1:0] i_cfg_wr_data,
    sgr_in_if.sink                        i_in,
    sgr_out_if.source                     o_out
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int KW = (CW > sgr_pkg::CFG_WIDTH) ? CW : sgr_pkg::CFG_WIDTH;

    sgr_pkg::t_state r_state;

    logic [sgr_pkg::CFG_WIDTH-1:0] r_group_size;
    logic [CW-1:0]                 r_fill;
    logic [VALUE_WIDTH-1:0]        r_mem [MAX_GROUP];

    logic [IW-1:0] r_rd_idx;
    logic [CW-1:0] r_left;
    logic          r_rev;
    logic          r_end;

    logic                   r_rd_pend;
    logic                   r_rd_last;
    logic                   r_rd_end;
    logic [VALUE_WIDTH-1:0] r_rd_data;

    logic                   r_out_vld;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_last;
    logic                   r_out_end;
    logic                   r_skid_vld;
    logic [VALUE_WIDTH-1:0] r_skid_value;
    logic                   r_skid_last;
    logic                   r_skid_end;

    logic          in_acc;
    logic          pop;
    logic          issue;
    logic [KW-1:0] cfg_ext;
    logic [KW-1:0] eff_k;
    logic [CW-1:0] fill_inc;
    logic          full_grp;
    logic          emit;
    logic [1:0]    occ;

    assign in_acc   = i_in.valid && i_in.ready;
    assign pop      = r_out_vld && o_out.ready;
    assign fill_inc = r_fill + CW'(1);

    // zero acts as one, oversize saturates
    always_comb begin
        cfg_ext = KW'(r_group_size);
        if (cfg_ext == '0) begin
            eff_k = KW'(1);
        end else if (cfg_ext > KW'(MAX_GROUP)) begin
            eff_k = KW'(MAX_GROUP);
        end else begin
            eff_k = cfg_ext;
        end
    end

    assign full_grp = KW'(fill_inc) >= eff_k;
    assign emit     = full_grp || i_in.list_end;

    // words held or on their way: read in flight, output and skid registers
    assign occ   = 2'((r_out_vld && !pop) ? 1 : 0) + 2'(r_skid_vld) + 2'(r_rd_pend);
    assign issue = (r_state == sgr_pkg::ST_DRAIN) && (occ < 2'd2);

    assign i_in.ready         = (r_state == sgr_pkg::ST_IDLE);
    assign o_out.valid        = r_out_vld;
    assign o_out.out_value    = r_out_value;
    assign o_out.run_last     = r_out_last;
    assign o_out.out_list_end = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= sgr_pkg::GROUP_SIZE_RST;
        end else if (i_cfg_wr_en) begin
            r_group_size <= i_cfg_wr_data;
        end
    end

    // group buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[IW'(r_fill)] <= i_in.item_value;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sgr_pkg::ST_IDLE;
            r_fill    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= issue;
            case (r_state)
                sgr_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        if (emit) begin
                            r_state <= sgr_pkg::ST_DRAIN;
                            r_fill  <= '0;
                        end else begin
                            r_fill <= fill_inc;
                        end
                    end
                end
                sgr_pkg::ST_DRAIN: begin
                    if (issue && r_left == CW'(1)) begin
                        r_state <= sgr_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= sgr_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // drain sequencer
    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_left <= fill_inc;
            r_rev  <= full_grp;
            r_end  <= i_in.list_end;
            if (full_grp) begin
                r_rd_idx <= IW'(r_fill);
            end else begin
                r_rd_idx <= '0;
            end
        end else if (issue) begin
            r_left <= r_left - CW'(1);
            if (r_rev) begin
                r_rd_idx <= r_rd_idx - IW'(1);
            end else begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
        end
        if (issue) begin
            r_rd_last <= (r_left == CW'(1));
            r_rd_end  <= (r_left == CW'(1)) && r_end;
        end
    end

    // two-word output queue: output register in front, skid behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || pop) begin
                if (r_skid_vld) begin
                    r_out_vld    <= 1'b1;
                    r_out_value  <= r_skid_value;
                    r_out_last   <= r_skid_last;
                    r_out_end    <= r_skid_end;
                    r_skid_vld   <= r_rd_pend;
                    r_skid_value <= r_rd_data;
                    r_skid_last  <= r_rd_last;
                    r_skid_end   <= r_rd_end;
                end else begin
                    r_out_vld   <= r_rd_pend;
                    r_out_value <= r_rd_data;
                    r_out_last  <= r_rd_last;
                    r_out_end   <= r_rd_end;
                end
            end else if (r_rd_pend) begin
                r_skid_vld   <= 1'b1;
                r_skid_value <= r_rd_data;
                r_skid_last  <= r_rd_last;
                r_skid_end   <= r_rd_end;
            end
        end
    end

    a_queue_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_pend && r_skid_vld && r_out_vld && !pop))
        else $error("output queue overflow");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a word while output register is empty");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CW'(MAX_GROUP))
        else $error("fill count reached buffer depth");

    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && emit) |=> (r_state == sgr_pkg::ST_DRAIN && r_left != '0 && r_fill == '0))
        else $error("group release did not start a drain");

    a_last_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_end) |-> r_out_last)
        else $error("list end without run end");

endmodule
